FILE: src/priority_task_scheduler_unit_assert.svh
// Assertion macros for the priority task scheduler.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef PRIORITY_TASK_SCHEDULER_UNIT_ASSERT_SVH
`define PRIORITY_TASK_SCHEDULER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pts: assertion failed");

// Next-cycle implication, checked outside reset
`define PTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pts: assertion failed");

`endif

FILE: src/pts_pkg.sv
// Shared types and constants for the priority task scheduler.
// No dependencies; used by the controller, datapath, top level and bench files.
`timescale 1ns / 1ps

package pts_pkg;

  // Default task table depth
  localparam int unsigned MAX_TASKS_DEF = 16;

  // Action codes of an input transaction
  typedef enum logic [2:0] {
    ACT_CREATE    = 3'd0,
    ACT_TERMINATE = 3'd1,
    ACT_YIELD     = 3'd2,
    ACT_BLOCK     = 3'd3,
    ACT_UNBLOCK   = 3'd4,
    ACT_TICK      = 3'd5
  } action_e;

  // Result status codes
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_FULL     = 2'd1;
  localparam logic [1:0] STS_NOTFOUND = 2'd2;
  localparam logic [1:0] STS_NOCHANGE = 2'd3;

  // One table entry apart from its blocked flag
  typedef struct packed {
    logic [15:0] pid;
    logic [7:0]  prio;
  } info_t;

  // Controller to datapath commands
  typedef struct packed {
    logic init;        // write the idle task into position zero
    logic take;        // input transaction accepted this cycle
    logic scan_look;   // scan for the target pid
    logic scan_sched;  // scan for the best ready task
    logic scan_shift;  // close the gap left by a removed task
    logic look_hit;    // target pid found at the current read position
    logic look_miss;   // target pid not in the table
    logic sched_end;   // scheduling scan complete
    logic shift_end;   // compaction complete
    logic emit;        // load the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] in_action;  // action of the transaction being offered
    logic [2:0] action;     // action of the transaction in progress
    logic       running;    // a current task exists
    logic       hit;        // lookup match at the current read position
    logic       scan_end;   // no more reads outstanding
    logic       out_free;   // output register can take a result
  } stat_t;

endpackage

FILE: src/pts_task_if.sv
// Input channel of the priority task scheduler: valid/ready plus task command.
// Depends on nothing.
`timescale 1ns / 1ps

interface pts_task_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  new_priority;
  logic [15:0] target_pid;

  modport source (output valid, output action, output new_priority, output target_pid,
                  input ready);
  modport sink (input valid, input action, input new_priority, input target_pid,
                output ready);
endinterface

FILE: src/pts_result_if.sv
// Output channel of the priority task scheduler: valid/ready plus result fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface pts_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] created_pid;
  logic        switched;
  logic        running_valid;
  logic [15:0] running_pid;
  logic [63:0] tick_total;

  modport source (output valid, output status, output created_pid, output switched,
                  output running_valid, output running_pid, output tick_total,
                  input ready);
  modport sink (input valid, input status, input created_pid, input switched,
                input running_valid, input running_pid, input tick_total,
                output ready);
endinterface

FILE: src/pts_ctrl.sv
// Sequencer of the priority task scheduler: walks each transaction through the
// lookup, scheduling and compaction phases that it needs. Depends on pts_pkg.
`timescale 1ns / 1ps

module pts_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pts_pkg::stat_t stat_i,
  output pts_pkg::cmd_t  cmd_o
);
  import pts_pkg::*;

  typedef enum logic [5:0] {
    ST_INIT  = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_LOOK  = 6'b000100,
    ST_SCHED = 6'b001000,
    ST_SHIFT = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          unique case (stat_i.in_action) inside
            ACT_TERMINATE, ACT_UNBLOCK: state_d = ST_LOOK;
            ACT_YIELD, ACT_TICK:        state_d = ST_SCHED;
            ACT_BLOCK:                  state_d = stat_i.running ? ST_SCHED : ST_DONE;
            default:                    state_d = ST_DONE;
          endcase
        end
      end
      ST_LOOK: begin
        cmd_o.scan_look = 1'b1;
        if (stat_i.hit) begin
          cmd_o.look_hit = 1'b1;
          state_d = (stat_i.action == ACT_TERMINATE) ? ST_SHIFT : ST_DONE;
        end else if (stat_i.scan_end) begin
          cmd_o.look_miss = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_SCHED: begin
        cmd_o.scan_sched = 1'b1;
        if (stat_i.scan_end) begin
          cmd_o.sched_end = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_SHIFT: begin
        cmd_o.scan_shift = 1'b1;
        if (stat_i.scan_end) begin
          cmd_o.shift_end = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: src/pts_dpath.sv
// Datapath of the priority task scheduler: task table memories in creation
// order, running-task registers, scan unit and output register. Depends on pts_pkg.
`timescale 1ns / 1ps

module pts_dpath #(
  parameter int unsigned MAX_TASKS = pts_pkg::MAX_TASKS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [2:0]     in_action_i,
  input  logic [7:0]     in_priority_i,
  input  logic [15:0]    in_target_i,
  input  pts_pkg::cmd_t  cmd_i,
  output pts_pkg::stat_t stat_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     out_status_o,
  output logic [15:0]    out_created_o,
  output logic           out_switched_o,
  output logic           out_running_valid_o,
  output logic [15:0]    out_running_pid_o,
  output logic [63:0]    out_tick_o
);
  import pts_pkg::*;

  localparam int unsigned PW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);

  // Table memories, indexed by creation-order position
  info_t info_mem [MAX_TASKS];
  logic  blk_mem  [MAX_TASKS];
  info_t rinfo_q;
  logic  rblk_q;

  logic          info_we, blk_we;
  logic [PW-1:0] waddr, raddr;
  info_t         info_wdata;
  logic          blk_wdata;

  // Scheduler state
  logic [CW-1:0] len_q, len_d;
  logic [PW-1:0] run_pos_q, run_pos_d;
  logic          run_present_q, run_present_d;
  logic [15:0]   run_pid_q, run_pid_d;
  logic [15:0]   pid_ctr_q, pid_ctr_d;
  logic [63:0]   tick_q, tick_d;

  // Transaction in progress
  logic [2:0]    act_q, act_d;
  logic [15:0]   target_q, target_d;
  logic [1:0]    status_q, status_d;
  logic [15:0]   created_q, created_d;
  logic          switched_q, switched_d;

  // Scan unit
  logic [CW-1:0] cnt_q, cnt_d;
  logic          dv_q, dv_d;
  logic [PW-1:0] pos_q, pos_d;
  logic          best_v_q, best_v_d;
  logic [PW-1:0] best_pos_q, best_pos_d;
  logic [7:0]    best_prio_q, best_prio_d;
  logic [15:0]   best_pid_q, best_pid_d;
  logic          scan_any, issue, hit, cand;

  // Output register
  logic          out_valid_q, out_valid_d;
  logic [1:0]    out_status_q, out_status_d;
  logic [15:0]   out_created_q, out_created_d;
  logic          out_switched_q, out_switched_d;
  logic          out_rv_q, out_rv_d;
  logic [15:0]   out_rpid_q, out_rpid_d;
  logic [63:0]   out_tick_q, out_tick_d;

  assign scan_any = cmd_i.scan_look | cmd_i.scan_sched | cmd_i.scan_shift;
  assign issue    = scan_any && (cnt_q < len_q);
  assign hit      = cmd_i.scan_look && dv_q && (rinfo_q.pid == target_q);
  assign raddr    = cnt_q[PW-1:0];
  assign cand     = !(run_present_q && (pos_q == run_pos_q)) && !rblk_q;

  // Status to the controller
  always_comb begin
    stat_o.in_action = in_action_i;
    stat_o.action    = act_q;
    stat_o.running   = run_present_q;
    stat_o.hit       = hit;
    stat_o.scan_end  = scan_any && !issue && !dv_q;
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

  // Next-state logic of the datapath
  always_comb begin
    len_d         = len_q;
    run_pos_d     = run_pos_q;
    run_present_d = run_present_q;
    run_pid_d     = run_pid_q;
    pid_ctr_d     = pid_ctr_q;
    tick_d        = tick_q;
    act_d         = act_q;
    target_d      = target_q;
    status_d      = status_q;
    created_d     = created_q;
    switched_d    = switched_q;
    cnt_d         = cnt_q;
    dv_d          = 1'b0;
    pos_d         = pos_q;
    best_v_d      = best_v_q;
    best_pos_d    = best_pos_q;
    best_prio_d   = best_prio_q;
    best_pid_d    = best_pid_q;
    info_we       = 1'b0;
    blk_we        = 1'b0;
    waddr         = run_pos_q;
    info_wdata    = rinfo_q;
    blk_wdata     = 1'b0;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_status_d  = out_status_q;
    out_created_d = out_created_q;
    out_switched_d = out_switched_q;
    out_rv_d      = out_rv_q;
    out_rpid_d    = out_rpid_q;
    out_tick_d    = out_tick_q;

    // Idle task goes into position zero after reset
    if (cmd_i.init) begin
      info_we    = 1'b1;
      blk_we     = 1'b1;
      waddr      = '0;
      info_wdata = '{pid: 16'd1, prio: 8'd0};
      blk_wdata  = 1'b0;
    end

    // Accepted transaction: immediate side effects
    if (cmd_i.take) begin
      act_d      = in_action_i;
      target_d   = in_target_i;
      cnt_d      = '0;
      best_v_d   = 1'b0;
      status_d   = STS_NOCHANGE;
      created_d  = '0;
      switched_d = 1'b0;
      case (in_action_i)
        ACT_CREATE: begin
          if (len_q < CW'(MAX_TASKS)) begin
            info_we    = 1'b1;
            blk_we     = 1'b1;
            waddr      = len_q[PW-1:0];
            info_wdata = '{pid: pid_ctr_q, prio: in_priority_i};
            blk_wdata  = 1'b0;
            len_d      = len_q + CW'(1);
            created_d  = pid_ctr_q;
            pid_ctr_d  = (pid_ctr_q == 16'hFFFF) ? 16'd1 : pid_ctr_q + 16'd1;
            status_d   = STS_OK;
          end else begin
            status_d   = STS_FULL;
          end
        end
        ACT_YIELD: begin
          blk_we    = run_present_q;
          blk_wdata = 1'b0;
        end
        ACT_BLOCK: begin
          if (run_present_q) begin
            blk_we    = 1'b1;
            blk_wdata = 1'b1;
            status_d  = STS_OK;
          end
        end
        ACT_TICK: tick_d = tick_q + 64'd1;
        default: ;
      endcase
    end

    // Scan: one read issued per cycle, its data evaluated in the next cycle
    if (issue) begin
      cnt_d = cnt_q + CW'(1);
      dv_d  = 1'b1;
      pos_d = cnt_q[PW-1:0];
    end

    // Best candidate, first in creation order wins ties
    if (cmd_i.scan_sched && dv_q && cand && (!best_v_q || rinfo_q.prio > best_prio_q)) begin
      best_v_d    = 1'b1;
      best_pos_d  = pos_q;
      best_prio_d = rinfo_q.prio;
      best_pid_d  = rinfo_q.pid;
    end

    // Compaction: entry moves down by one position
    if (cmd_i.scan_shift && dv_q) begin
      info_we    = 1'b1;
      blk_we     = 1'b1;
      waddr      = pos_q - PW'(1);
      info_wdata = rinfo_q;
      blk_wdata  = rblk_q;
    end

    // Lookup result
    if (cmd_i.look_hit) begin
      if (act_q == ACT_TERMINATE) begin
        status_d = STS_OK;
        cnt_d    = CW'(pos_q) + CW'(1);
        dv_d     = 1'b0;
        if (run_present_q && run_pos_q == pos_q) begin
          run_present_d = 1'b0;
          switched_d    = 1'b1;
        end else if (run_pos_q > pos_q) begin
          run_pos_d = run_pos_q - PW'(1);
        end
      end else if (rblk_q) begin
        blk_we    = 1'b1;
        waddr     = pos_q;
        blk_wdata = 1'b0;
        status_d  = STS_OK;
      end
    end
    if (cmd_i.look_miss) begin
      status_d = STS_NOTFOUND;
    end

    if (cmd_i.shift_end) begin
      len_d = len_q - CW'(1);
    end

    // Switch to the chosen task
    if (cmd_i.sched_end && best_v_q) begin
      run_pos_d     = best_pos_q;
      run_pid_d     = best_pid_q;
      run_present_d = 1'b1;
      switched_d    = 1'b1;
      status_d      = STS_OK;
    end

    // Result into the output register
    if (cmd_i.emit) begin
      out_valid_d    = 1'b1;
      out_status_d   = status_q;
      out_created_d  = created_q;
      out_switched_d = switched_q;
      out_rv_d       = run_present_q;
      out_rpid_d     = run_present_q ? run_pid_q : 16'd0;
      out_tick_d     = tick_q;
    end
  end

  // Table memories: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (info_we) begin
      info_mem[waddr] <= info_wdata;
    end
    if (blk_we) begin
      blk_mem[waddr] <= blk_wdata;
    end
    rinfo_q <= info_mem[raddr];
    rblk_q  <= blk_mem[raddr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q         <= CW'(1);
      run_pos_q     <= '0;
      run_present_q <= 1'b1;
      run_pid_q     <= 16'd1;
      pid_ctr_q     <= 16'd2;
      tick_q        <= '0;
      act_q         <= ACT_CREATE;
      status_q      <= STS_NOCHANGE;
      created_q     <= '0;
      switched_q    <= 1'b0;
      cnt_q         <= '0;
      dv_q          <= 1'b0;
      best_v_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      len_q         <= len_d;
      run_pos_q     <= run_pos_d;
      run_present_q <= run_present_d;
      run_pid_q     <= run_pid_d;
      pid_ctr_q     <= pid_ctr_d;
      tick_q        <= tick_d;
      act_q         <= act_d;
      status_q      <= status_d;
      created_q     <= created_d;
      switched_q    <= switched_d;
      cnt_q         <= cnt_d;
      dv_q          <= dv_d;
      best_v_q      <= best_v_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    target_q       <= target_d;
    pos_q          <= pos_d;
    best_pos_q     <= best_pos_d;
    best_prio_q    <= best_prio_d;
    best_pid_q     <= best_pid_d;
    out_status_q   <= out_status_d;
    out_created_q  <= out_created_d;
    out_switched_q <= out_switched_d;
    out_rv_q       <= out_rv_d;
    out_rpid_q     <= out_rpid_d;
    out_tick_q     <= out_tick_d;
  end

  assign out_valid_o         = out_valid_q;
  assign out_status_o        = out_status_q;
  assign out_created_o       = out_created_q;
  assign out_switched_o      = out_switched_q;
  assign out_running_valid_o = out_rv_q;
  assign out_running_pid_o   = out_rpid_q;
  assign out_tick_o          = out_tick_q;

  // Checks
`include "priority_task_scheduler_unit_assert.svh"
  `PTS_ASSERT_IMP(a_len_bound, 1'b1, len_q <= CW'(MAX_TASKS))
  `PTS_ASSERT_IMP(a_run_in_table, run_present_q, CW'(run_pos_q) < len_q)
  `PTS_ASSERT_IMP(a_pid_ctr_nonzero, 1'b1, pid_ctr_q != 16'd0)
  `PTS_ASSERT_IMP(a_run_pid_nonzero, run_present_q, run_pid_q != 16'd0)
  `PTS_ASSERT_NXT(a_emit_valid, cmd_i.emit, out_valid_q)

endmodule

FILE: src/priority_task_scheduler_unit.sv
// Priority task scheduler: task table with create, terminate, yield, block,
// unblock and tick. Each transaction yields one result. Create and unused
// actions need no scan; yield, tick and block (while a task runs) scan the
// table one entry a cycle; terminate and unblock scan for the pid, and
// terminate then moves later entries down one a cycle. After reset the init
// state loads the idle task (pid 1) before input is taken. A finished result
// waits in an output register while the next task command is accepted; that
// command holds in its last cycle until the register is read.
// Depends on pts_pkg, pts_task_if, pts_result_if, pts_ctrl and pts_dpath.
`timescale 1ns / 1ps

module priority_task_scheduler_unit #(
  parameter int unsigned MAX_TASKS = pts_pkg::MAX_TASKS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  pts_task_if.sink     task_i,
  pts_result_if.source result_o
);
  import pts_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Controller
  pts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (task_i.valid),
    .in_ready_o (task_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath
  pts_dpath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_action_i         (task_i.action),
    .in_priority_i       (task_i.new_priority),
    .in_target_i         (task_i.target_pid),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .out_valid_o         (result_o.valid),
    .out_ready_i         (result_o.ready),
    .out_status_o        (result_o.status),
    .out_created_o       (result_o.created_pid),
    .out_switched_o      (result_o.switched),
    .out_running_valid_o (result_o.running_valid),
    .out_running_pid_o   (result_o.running_pid),
    .out_tick_o          (result_o.tick_total)
  );

endmodule

FILE: bench/sched_outcome_check.sv
// Outcome checker for the priority task scheduler: watches both channels,
// tracks the task table and compares every result. Depends on pts_pkg,
// pts_task_if and pts_result_if.
`timescale 1ns / 1ps

module sched_outcome_check #(
  parameter int unsigned TABLE_DEPTH = pts_pkg::MAX_TASKS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  pts_task_if                          task_mon,
  pts_result_if                        result_mon,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o,
  output logic [4:0]                   live_count_o,
  output logic [TABLE_DEPTH-1:0][15:0] live_pid_o,
  output logic [TABLE_DEPTH-1:0]       live_blocked_o
);
  import pts_pkg::*;

  typedef enum logic [1:0] {
    SLOT_READY,
    SLOT_RUNNING,
    SLOT_BLOCKED
  } slot_state_e;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] created_pid;
    logic        switched;
    logic        running_valid;
    logic [15:0] running_pid;
    logic [63:0] tick_total;
  } sched_result_t;

  // Task table copy
  bit          slot_used  [TABLE_DEPTH];
  slot_state_e slot_state [TABLE_DEPTH];
  logic [7:0]  slot_prio  [TABLE_DEPTH];
  logic [15:0] slot_pid   [TABLE_DEPTH];
  int          age_order  [$];  // live slots, oldest first
  int          cur_slot;
  bit          cur_present;
  logic [15:0] pid_next;
  logic [63:0] tick_count;

  sched_result_t outcome_q [$];
  int unsigned   mismatches = 0;

  // Position in creation order of the oldest task with this pid, -1 if none
  function automatic int find_by_pid(logic [15:0] p);
    int i;
    for (i = 0; i < age_order.size(); i++) begin
      if (slot_pid[age_order[i]] == p) return i;
    end
    return -1;
  endfunction

  // Pick the best ready task other than the current one; oldest wins ties
  function automatic bit dispatch_best();
    int best;
    int i;
    int s;
    best = -1;
    for (i = 0; i < age_order.size(); i++) begin
      s = age_order[i];
      if (!(cur_present && s == cur_slot) && slot_state[s] == SLOT_READY) begin
        if (best < 0 || slot_prio[s] > slot_prio[best]) best = s;
      end
    end
    if (best < 0) return 1'b0;
    if (cur_present && slot_state[cur_slot] != SLOT_BLOCKED) slot_state[cur_slot] = SLOT_READY;
    slot_state[best] = SLOT_RUNNING;
    cur_slot = best;
    cur_present = 1'b1;
    return 1'b1;
  endfunction

  // Apply one transaction to the table and return the result it must give
  function automatic sched_result_t predict_outcome(logic [2:0] act, logic [7:0] prio,
                                                    logic [15:0] target);
    sched_result_t r;
    bit was_present;
    int was_slot;
    int free_slot;
    int pos;
    int s;
    int i;
    r = '0;
    r.status = STS_NOCHANGE;
    was_present = cur_present;
    was_slot = cur_slot;
    case (act)
      ACT_CREATE: begin
        free_slot = -1;
        for (i = TABLE_DEPTH - 1; i >= 0; i--) begin
          if (!slot_used[i]) free_slot = i;
        end
        if (free_slot < 0 || age_order.size() >= TABLE_DEPTH) begin
          r.status = STS_FULL;
        end else begin
          r.created_pid = pid_next;
          pid_next = pid_next + 16'd1;
          if (pid_next == 16'd0) pid_next = 16'd1;
          slot_used[free_slot] = 1'b1;
          slot_state[free_slot] = SLOT_READY;
          slot_prio[free_slot] = prio;
          slot_pid[free_slot] = r.created_pid;
          age_order.push_back(free_slot);
          r.status = STS_OK;
        end
      end
      ACT_TERMINATE: begin
        pos = find_by_pid(target);
        if (pos < 0) begin
          r.status = STS_NOTFOUND;
        end else begin
          s = age_order[pos];
          age_order.delete(pos);
          slot_used[s] = 1'b0;
          slot_state[s] = SLOT_READY;
          slot_prio[s] = '0;
          slot_pid[s] = '0;
          if (cur_present && cur_slot == s) cur_present = 1'b0;
          r.status = STS_OK;
        end
      end
      ACT_YIELD: begin
        if (cur_present) slot_state[cur_slot] = SLOT_READY;
        r.status = dispatch_best() ? STS_OK : STS_NOCHANGE;
      end
      ACT_BLOCK: begin
        if (cur_present) begin
          slot_state[cur_slot] = SLOT_BLOCKED;
          void'(dispatch_best());
          r.status = STS_OK;
        end
      end
      ACT_UNBLOCK: begin
        pos = find_by_pid(target);
        if (pos < 0) begin
          r.status = STS_NOTFOUND;
        end else if (slot_state[age_order[pos]] == SLOT_BLOCKED) begin
          slot_state[age_order[pos]] = SLOT_READY;
          r.status = STS_OK;
        end
      end
      ACT_TICK: begin
        tick_count = tick_count + 64'd1;
        r.status = dispatch_best() ? STS_OK : STS_NOCHANGE;
      end
      default: ;  // spare codes leave everything as it is
    endcase
    if (was_present != cur_present) r.switched = 1'b1;
    else r.switched = cur_present && (was_slot != cur_slot);
    r.running_valid = cur_present;
    r.running_pid = cur_present ? slot_pid[cur_slot] : 16'd0;
    r.tick_total = tick_count;
    return r;
  endfunction

  task automatic report_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Track transactions on both channels
  always @(posedge clk_i or negedge rst_ni) begin : track
    sched_result_t want;
    int i;
    if (!rst_ni) begin
      for (i = 0; i < TABLE_DEPTH; i++) begin
        slot_used[i] = 1'b0;
        slot_state[i] = SLOT_READY;
        slot_prio[i] = '0;
        slot_pid[i] = '0;
      end
      slot_used[0] = 1'b1;
      slot_pid[0] = 16'd1;
      age_order = {0};
      cur_slot = 0;
      cur_present = 1'b1;
      pid_next = 16'd2;
      tick_count = '0;
      outcome_q.delete();
    end else begin
      if (task_mon.valid && task_mon.ready) begin
        outcome_q.push_back(predict_outcome(task_mon.action, task_mon.new_priority,
                                            task_mon.target_pid));
      end
      if (result_mon.valid && result_mon.ready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: result with no transaction outstanding, expected none, got status %0d",
                   $time, result_mon.status);
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          report_field("status", want.status, result_mon.status);
          report_field("created_pid", want.created_pid, result_mon.created_pid);
          report_field("switched", want.switched, result_mon.switched);
          report_field("running_valid", want.running_valid, result_mon.running_valid);
          report_field("running_pid", want.running_pid, result_mon.running_pid);
          report_field("tick_total", want.tick_total, result_mon.tick_total);
        end
      end
    end

    // Table view for the stimulus side
    fail_count_o = mismatches;
    pending_o = outcome_q.size();
    live_count_o = 5'(age_order.size());
    for (i = 0; i < TABLE_DEPTH; i++) begin
      if (i < age_order.size()) begin
        live_pid_o[i] = slot_pid[age_order[i]];
        live_blocked_o[i] = (slot_state[age_order[i]] == SLOT_BLOCKED);
      end else begin
        live_pid_o[i] = '0;
        live_blocked_o[i] = 1'b0;
      end
    end
  end

endmodule

FILE: bench/priority_task_scheduler_unit_tb.sv
// Testbench top for the priority task scheduler: clock, reset, stimulus and
// verdict. Depends on pts_pkg, both channel interfaces, the block and
// sched_outcome_check.
`timescale 1ns / 1ps

module priority_task_scheduler_unit_tb;
  import pts_pkg::*;

  localparam int unsigned TABLE_DEPTH    = MAX_TASKS_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned BUSY_ITEMS     = 850;
  localparam int unsigned CALM_ITEMS     = 150;
  localparam int unsigned DRAIN_CYCLES   = 60;
  // Action codes the block does not define
  localparam logic [2:0]  ACT_SPARE_LO   = 3'd6;
  localparam logic [2:0]  ACT_SPARE_HI   = 3'd7;

  logic clk_i;
  logic rst_ni;
  bit   idle_on;

  int unsigned                  fails;
  int unsigned                  pending;
  logic [4:0]                   live_count;
  logic [TABLE_DEPTH-1:0][15:0] live_pid;
  logic [TABLE_DEPTH-1:0]       live_blocked;
  int unsigned                  quiet_cycles = 0;

  pts_task_if   task_ch ();
  pts_result_if result_ch ();

  priority_task_scheduler_unit #(
    .MAX_TASKS(TABLE_DEPTH)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .task_i  (task_ch),
    .result_o(result_ch)
  );

  sched_outcome_check #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) outcome_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .task_mon      (task_ch),
    .result_mon    (result_ch),
    .fail_count_o  (fails),
    .pending_o     (pending),
    .live_count_o  (live_count),
    .live_pid_o    (live_pid),
    .live_blocked_o(live_blocked)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Result side backpressure
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk_i);
      end
      result_ch.ready <= 1'b1;
    end
  end

  // Watchdog: too long without any transaction on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (task_ch.valid && task_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("priority_task_scheduler_unit_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(logic [2:0] act, logic [7:0] prio, logic [15:0] target);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      task_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    task_ch.valid        <= 1'b1;
    task_ch.action       <= act;
    task_ch.new_priority <= prio;
    task_ch.target_pid   <= target;
    @(posedge clk_i);
    while (!task_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Priorities lean on the extremes so ties are common
  function automatic logic [7:0] rand_prio();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly a live pid (a blocked one when asked), sometimes a stray value
  function automatic logic [15:0] pick_target(bit want_blocked);
    int unsigned n;
    int unsigned k;
    int unsigned i;
    n = 32'(live_count);
    case ($urandom_range(0, 9))
      0:       return 16'($urandom_range(0, 65535));
      1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: ;
    endcase
    if (n == 0) return 16'($urandom_range(0, 65535));
    if (want_blocked && live_blocked != '0) begin
      k = $urandom_range(0, n - 1);
      for (i = 0; i < n; i++) begin
        if (live_blocked[(k + i) % n]) return live_pid[(k + i) % n];
      end
    end
    return live_pid[$urandom_range(0, n - 1)];
  endfunction

  // Random mix; the share of creates changes every 50 items so the table
  // swings between empty and full
  task automatic random_run(int unsigned count, bit allow_idle);
    int unsigned n;
    int unsigned create_pct;
    int unsigned r;
    create_pct = 25;
    for (n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        idle_on = allow_idle && ($urandom_range(0, 4) != 0);
        case ($urandom_range(0, 2))
          0:       create_pct = 8;
          1:       create_pct = 22;
          default: create_pct = 45;
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_item($urandom_range(0, 1) ? ACT_SPARE_LO : ACT_SPARE_HI, rand_prio(),
                  16'($urandom_range(0, 65535)));
      end else if (r < 3 + create_pct) begin
        send_item(ACT_CREATE, rand_prio(), 16'($urandom_range(0, 65535)));
      end else begin
        case ($urandom_range(0, 4))
          0:       send_item(ACT_TERMINATE, rand_prio(), pick_target(1'b0));
          1:       send_item(ACT_YIELD, rand_prio(), 16'($urandom_range(0, 65535)));
          2:       send_item(ACT_BLOCK, rand_prio(), 16'($urandom_range(0, 65535)));
          3:       send_item(ACT_UNBLOCK, rand_prio(), pick_target(1'b1));
          default: send_item(ACT_TICK, rand_prio(), 16'($urandom_range(0, 65535)));
        endcase
      end
    end
  endtask

  initial begin : stimulus
    task_ch.valid        = 1'b0;
    task_ch.action       = ACT_CREATE;
    task_ch.new_priority = '0;
    task_ch.target_pid   = '0;
    idle_on              = 1'b1;
    rst_ni               = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: only the idle task exists
    send_item(ACT_YIELD, 8'h00, 16'h0000);      // nothing to switch to
    send_item(ACT_TICK, 8'hFF, 16'hFFFF);       // same, tick still counts
    send_item(ACT_BLOCK, 8'h00, 16'h0000);      // blocked but stays current
    send_item(ACT_UNBLOCK, 8'h00, 16'd1);
    send_item(ACT_UNBLOCK, 8'h00, 16'd1);       // not blocked any more
    send_item(ACT_UNBLOCK, 8'h00, 16'hFFFF);    // unknown pid
    send_item(ACT_TERMINATE, 8'h00, 16'h0000);  // free slots hold pid zero, not live
    // Priority ties go to the oldest task
    send_item(ACT_CREATE, 8'hFF, 16'h0000);
    send_item(ACT_CREATE, 8'h00, 16'h0000);
    send_item(ACT_CREATE, 8'hFF, 16'h0000);
    send_item(ACT_TICK, 8'h00, 16'h0000);
    send_item(ACT_YIELD, 8'h00, 16'h0000);
    send_item(ACT_YIELD, 8'h00, 16'h0000);
    send_item(ACT_BLOCK, 8'h00, 16'h0000);
    send_item(ACT_TERMINATE, 8'h00, 16'd4);     // current task goes away
    send_item(ACT_BLOCK, 8'h00, 16'h0000);      // no current task
    send_item(ACT_YIELD, 8'h00, 16'h0000);
    send_item(ACT_UNBLOCK, 8'h00, 16'd2);
    send_item(ACT_SPARE_LO, 8'hFF, 16'hFFFF);
    send_item(ACT_SPARE_HI, 8'hFF, 16'hFFFF);
    // Fill the table, overflow it, then reuse a slot in the middle
    while (live_count < TABLE_DEPTH) send_item(ACT_CREATE, rand_prio(), 16'h0000);
    send_item(ACT_CREATE, 8'd7, 16'h0000);
    send_item(ACT_TERMINATE, 8'h00, 16'd3);
    send_item(ACT_CREATE, 8'd128, 16'h0000);
    send_item(ACT_TICK, 8'h00, 16'h0000);

    random_run(BUSY_ITEMS, 1'b1);

    // Last part runs without idle cycles
    idle_on = 1'b0;
    random_run(CALM_ITEMS, 1'b0);
    task_ch.valid <= 1'b0;

    // Drain, then allow for a late or extra result
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0) begin
      $display("priority_task_scheduler_unit_tb passed");
    end else begin
      $display("priority_task_scheduler_unit_tb failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/pts_pkg.sv
src/pts_task_if.sv
src/pts_result_if.sv
src/pts_ctrl.sv
src/pts_dpath.sv
src/priority_task_scheduler_unit.sv
bench/sched_outcome_check.sv
bench/priority_task_scheduler_unit_tb.sv
